// File: src/cbpe_pkg.sv
// ----------------------------------------------------------------------------
// cbpe_pkg
// Shared types and constants for the cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
package cbpe_pkg;

  localparam int unsigned STEPS_DEF = 100;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned KIDX_W    = 7;
  localparam int unsigned T_W       = 17;   // Q0.16 value in 0..65536
  localparam int unsigned T_ONE     = 65536;
  localparam int unsigned SQ_W      = 33;   // T*T, U*U
  localparam int unsigned TU_W      = 31;   // T*U
  localparam int unsigned WGT_W     = 49;   // Q0.48 weight in 0..2^48
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned PT_W      = 24;
  localparam int unsigned RND_SH    = 40;
  localparam int unsigned NPT       = 4;
  localparam int unsigned NLANE     = 2 * NPT;

  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (RND_SH - 1);

  typedef logic [T_W-1:0]   tq_t;
  typedef logic [WGT_W-1:0] wgt_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [PT_W-1:0]    pt_t;

  // Load enables of the three weight stages.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } wgt_ctl_t;

endpackage

// File: src/cbpe_if.sv
// ----------------------------------------------------------------------------
// cbpe_in_if / cbpe_out_if
// Valid/ready channels for control-point transactions and curve points.
// ----------------------------------------------------------------------------
interface cbpe_in_if;
  logic                         valid;
  logic                         ready;
  logic signed [15:0]           p1_x;
  logic signed [15:0]           p1_y;
  logic signed [15:0]           p2_x;
  logic signed [15:0]           p2_y;
  logic signed [15:0]           p3_x;
  logic signed [15:0]           p3_y;
  logic signed [15:0]           p4_x;
  logic signed [15:0]           p4_y;
  logic [6:0]                   sample_index;

  modport source (
    output valid, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y, sample_index,
    input  ready
  );
  modport sink (
    input  valid, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y, sample_index,
    output ready
  );
endinterface

interface cbpe_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;

  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

// File: src/cbpe_weight.sv
// ----------------------------------------------------------------------------
// cbpe_weight
// Maps the sample index to T, U = 1 - T and the four Bernstein weights.
// ----------------------------------------------------------------------------
module cbpe_weight #(
  parameter int unsigned STEPS = cbpe_pkg::STEPS_DEF
) (
  input  logic                          clk,
  input  cbpe_pkg::wgt_ctl_t            ctl,
  input  logic [cbpe_pkg::KIDX_W-1:0]   kidx,
  output cbpe_pkg::wgt_t                wgt [cbpe_pkg::NPT]
);

  localparam int unsigned NTAB = 2 ** cbpe_pkg::KIDX_W;

  cbpe_pkg::tq_t t_tab [NTAB];

  for (genvar g = 0; g < NTAB; g++) begin : g_tab
    localparam longint unsigned KS = (g > STEPS) ? STEPS : g;
    localparam longint unsigned TV =
      (2 * KS * cbpe_pkg::T_ONE + STEPS) / (2 * STEPS);
    localparam longint unsigned TC = (TV > cbpe_pkg::T_ONE) ? cbpe_pkg::T_ONE : TV;
    assign t_tab[g] = cbpe_pkg::T_W'(TC);
  end

  cbpe_pkg::tq_t               t1_r, u1_r, t2_r, u2_r;
  logic [cbpe_pkg::SQ_W-1:0]   tt_r, uu_r;
  logic [cbpe_pkg::TU_W-1:0]   tu_r;
  cbpe_pkg::wgt_t              w_r [cbpe_pkg::NPT];

  logic [2*cbpe_pkg::T_W-1:0]              tt_nxt, uu_nxt, tu_nxt;
  logic [cbpe_pkg::SQ_W+cbpe_pkg::T_W-1:0] w0_nxt, w3_nxt;
  logic [cbpe_pkg::TU_W+cbpe_pkg::T_W-1:0] ttu_nxt, tuu_nxt;

  always_comb begin
    tt_nxt  = t1_r * t1_r;
    uu_nxt  = u1_r * u1_r;
    tu_nxt  = t1_r * u1_r;
    w0_nxt  = tt_r * t2_r;
    w3_nxt  = uu_r * u2_r;
    ttu_nxt = tu_r * t2_r;
    tuu_nxt = tu_r * u2_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      t1_r <= t_tab[kidx];
      u1_r <= cbpe_pkg::T_W'(cbpe_pkg::T_ONE) - t_tab[kidx];
    end
    if (ctl.ld2) begin
      t2_r <= t1_r;
      u2_r <= u1_r;
      tt_r <= tt_nxt[cbpe_pkg::SQ_W-1:0];
      uu_r <= uu_nxt[cbpe_pkg::SQ_W-1:0];
      tu_r <= tu_nxt[cbpe_pkg::TU_W-1:0];
    end
    if (ctl.ld3) begin
      w_r[0] <= w0_nxt[cbpe_pkg::WGT_W-1:0];
      w_r[1] <= cbpe_pkg::WGT_W'(ttu_nxt) + {ttu_nxt[cbpe_pkg::WGT_W-2:0], 1'b0};
      w_r[2] <= cbpe_pkg::WGT_W'(tuu_nxt) + {tuu_nxt[cbpe_pkg::WGT_W-2:0], 1'b0};
      w_r[3] <= w3_nxt[cbpe_pkg::WGT_W-1:0];
    end
  end

  assign wgt = w_r;

endmodule

// File: src/cbpe_lane.sv
// ----------------------------------------------------------------------------
// cbpe_lane
// One coordinate times its weight, registered.
// ----------------------------------------------------------------------------
module cbpe_lane (
  input  logic              clk,
  input  logic              en,
  input  cbpe_pkg::coord_t  coord,
  input  cbpe_pkg::wgt_t    wgt,
  output cbpe_pkg::acc_t    prod
);

  logic signed [cbpe_pkg::COORD_W+cbpe_pkg::WGT_W:0] prod_nxt;
  cbpe_pkg::acc_t                                    prod_r;

  assign prod_nxt = coord * $signed({1'b0, wgt});

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt[cbpe_pkg::ACC_W-1:0];
    end
  end

  assign prod = prod_r;

endmodule

// File: src/cbpe_merge.sv
// ----------------------------------------------------------------------------
// cbpe_merge
// Adds the lane products per axis, rounds half up to 8 fraction bits.
// ----------------------------------------------------------------------------
module cbpe_merge (
  input  logic            clk,
  input  logic            en_pair,
  input  logic            en_out,
  input  cbpe_pkg::acc_t  prod [cbpe_pkg::NLANE],
  output cbpe_pkg::pt_t   point_x,
  output cbpe_pkg::pt_t   point_y
);

  cbpe_pkg::acc_t  lo_r [2];
  cbpe_pkg::acc_t  hi_r [2];
  cbpe_pkg::acc_t  sum_nxt [2];
  cbpe_pkg::pt_t   pt_r [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      sum_nxt[a] = lo_r[a] + hi_r[a] + cbpe_pkg::RND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      if (en_pair) begin
        lo_r[a] <= prod[a] + prod[2 + a];
        hi_r[a] <= prod[4 + a] + prod[6 + a];
      end
      if (en_out) begin
        pt_r[a] <= sum_nxt[a][cbpe_pkg::ACC_W-1:cbpe_pkg::RND_SH];
      end
    end
  end

  assign point_x = pt_r[0];
  assign point_y = pt_r[1];

endmodule

// File: src/cubic_bezier_point_eval_top.sv
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval_top
// Pipeline: 6 register stages between the accepting edge and a valid result.
// Throughput: one transaction per cycle; each stage holds under back-pressure.
// Weights take three stages (lookup, two multiplies), then eight lanes and a
// two-stage merge.
// Reset (synchronous, active low) clears the stage valid bits only.
// ----------------------------------------------------------------------------
module cubic_bezier_point_eval_top #(
  parameter int unsigned STEPS = cbpe_pkg::STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  cbpe_in_if.sink      in_ch,
  cbpe_out_if.source   out_ch
);

  localparam int unsigned NSTG = 6;

  logic [NSTG-1:0]          vld_r;
  logic [NSTG-1:0]          en;
  cbpe_pkg::coord_t         pts_r [3][cbpe_pkg::NLANE];
  cbpe_pkg::wgt_t           wgt [cbpe_pkg::NPT];
  cbpe_pkg::acc_t           prod [cbpe_pkg::NLANE];
  cbpe_pkg::wgt_ctl_t       wctl;

  always_comb begin
    en[NSTG-1] = ~vld_r[NSTG-1] | out_ch.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = ~vld_r[i] | en[i+1];
    end
  end

  assign in_ch.ready = en[0];
  assign wctl = '{ld1: en[0], ld2: en[1], ld3: en[2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_ch.valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pts_r[0][0] <= in_ch.p1_x;
      pts_r[0][1] <= in_ch.p1_y;
      pts_r[0][2] <= in_ch.p2_x;
      pts_r[0][3] <= in_ch.p2_y;
      pts_r[0][4] <= in_ch.p3_x;
      pts_r[0][5] <= in_ch.p3_y;
      pts_r[0][6] <= in_ch.p4_x;
      pts_r[0][7] <= in_ch.p4_y;
    end
    if (en[1]) begin
      pts_r[1] <= pts_r[0];
    end
    if (en[2]) begin
      pts_r[2] <= pts_r[1];
    end
  end

  cbpe_weight #(
    .STEPS (STEPS)
  ) u_weight (
    .clk  (clk),
    .ctl  (wctl),
    .kidx (in_ch.sample_index),
    .wgt  (wgt)
  );

  for (genvar l = 0; l < cbpe_pkg::NLANE; l++) begin : g_lane
    cbpe_lane u_lane (
      .clk   (clk),
      .en    (en[3]),
      .coord (pts_r[2][l]),
      .wgt   (wgt[l/2]),
      .prod  (prod[l])
    );
  end

  cbpe_merge u_merge (
    .clk     (clk),
    .en_pair (en[4]),
    .en_out  (en[5]),
    .prod    (prod),
    .point_x (out_ch.point_x),
    .point_y (out_ch.point_y)
  );

  assign out_ch.valid = vld_r[NSTG-1];

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cubic_bezier_point_eval_top. A driver sends
// control-point transactions from a queue; each accepted one is run through a
// fixed-point Bezier predictor. A monitor compares every returned curve point
// against the oldest prediction. Random valid gaps and ready stalls are used
// throughout, except in the final stretch of the run.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STEPS        = cbpe_pkg::STEPS_DEF;
  localparam int RANDOM_ITEMS = 1530;
  localparam int QUIET_TAIL   = 150;
  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    cbpe_pkg::coord_t             p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y;
    logic [cbpe_pkg::KIDX_W-1:0]  k;
  } ctrl_pts_t;

  typedef struct {
    cbpe_pkg::pt_t x;
    cbpe_pkg::pt_t y;
  } curve_pt_t;

  logic clk;
  logic rst_n;

  cbpe_in_if  in_ch ();
  cbpe_out_if out_ch ();

  cubic_bezier_point_eval_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ctrl_pts_t pending_ctrl[$];
  curve_pt_t expected_points[$];
  ctrl_pts_t cur_item;
  logic      quiet;
  int        gap_left, stall_left;
  int        n_sent, n_recv, n_clamped, n_errors, idle_cycles;

  always #4 clk = ~clk;

  // Q0.16 parameter, exact Q0.48 Bernstein weights, round half up to Q8.
  function automatic curve_pt_t eval_curve_point(input ctrl_pts_t c);
    longint unsigned kk, t, u;
    longint          w[4];
    longint          px[4], py[4];
    longint          acc_x, acc_y;
    curve_pt_t       r;
    kk = c.k;
    if (kk > STEPS) kk = STEPS;
    t = (2 * kk * cbpe_pkg::T_ONE + STEPS) / (2 * STEPS);
    if (t > cbpe_pkg::T_ONE) t = cbpe_pkg::T_ONE;
    u = cbpe_pkg::T_ONE - t;
    w[0] = t * t * t;
    w[1] = 3 * t * t * u;
    w[2] = 3 * t * u * u;
    w[3] = u * u * u;
    px[0] = c.p1_x; px[1] = c.p2_x; px[2] = c.p3_x; px[3] = c.p4_x;
    py[0] = c.p1_y; py[1] = c.p2_y; py[2] = c.p3_y; py[3] = c.p4_y;
    acc_x = 0;
    acc_y = 0;
    for (int i = 0; i < cbpe_pkg::NPT; i++) begin
      acc_x += px[i] * w[i];
      acc_y += py[i] * w[i];
    end
    acc_x += longint'(1) <<< (cbpe_pkg::RND_SH - 1);
    acc_y += longint'(1) <<< (cbpe_pkg::RND_SH - 1);
    r.x = cbpe_pkg::pt_t'(acc_x >>> cbpe_pkg::RND_SH);
    r.y = cbpe_pkg::pt_t'(acc_y >>> cbpe_pkg::RND_SH);
    return r;
  endfunction

  function automatic ctrl_pts_t make_ctrl(input int p1x, p1y, p2x, p2y,
                                          input int p3x, p3y, p4x, p4y, kv);
    ctrl_pts_t c;
    c.p1_x = cbpe_pkg::coord_t'(p1x); c.p1_y = cbpe_pkg::coord_t'(p1y);
    c.p2_x = cbpe_pkg::coord_t'(p2x); c.p2_y = cbpe_pkg::coord_t'(p2y);
    c.p3_x = cbpe_pkg::coord_t'(p3x); c.p3_y = cbpe_pkg::coord_t'(p3y);
    c.p4_x = cbpe_pkg::coord_t'(p4x); c.p4_y = cbpe_pkg::coord_t'(p4y);
    c.k    = cbpe_pkg::KIDX_W'(kv);
    return c;
  endfunction

  function automatic cbpe_pkg::coord_t rand_coord();
    case ($urandom_range(0, 15))
      0:       return cbpe_pkg::coord_t'(-32768);
      1:       return cbpe_pkg::coord_t'(32767);
      2:       return cbpe_pkg::coord_t'(0);
      3:       return cbpe_pkg::coord_t'(-1);
      default: return cbpe_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [cbpe_pkg::KIDX_W-1:0] rand_index();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return cbpe_pkg::KIDX_W'(0);
    if (sel == 1) return cbpe_pkg::KIDX_W'(STEPS);
    if (sel == 2)
      return cbpe_pkg::KIDX_W'($urandom_range(STEPS + 1, (1 << cbpe_pkg::KIDX_W) - 1));
    return cbpe_pkg::KIDX_W'($urandom_range(0, STEPS));
  endfunction

  function automatic ctrl_pts_t rand_ctrl();
    ctrl_pts_t         c;
    cbpe_pkg::coord_t  ax, ay;
    c.p1_x = rand_coord(); c.p1_y = rand_coord();
    c.p2_x = rand_coord(); c.p2_y = rand_coord();
    c.p3_x = rand_coord(); c.p3_y = rand_coord();
    c.p4_x = rand_coord(); c.p4_y = rand_coord();
    c.k    = rand_index();
    // degenerate curve: all control points coincide
    if ($urandom_range(0, 15) == 0) begin
      ax = c.p1_x;
      ay = c.p1_y;
      c.p2_x = ax; c.p3_x = ax; c.p4_x = ax;
      c.p2_y = ay; c.p3_y = ay; c.p4_y = ay;
    end
    return c;
  endfunction

  task automatic queue_item(input ctrl_pts_t c);
    pending_ctrl.insert(pending_ctrl.size(), c);
  endtask

  task automatic note_error(input string msg);
    if (n_errors < MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // Driver
  always @(posedge clk) begin : driver
    logic drv_valid;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      quiet       <= 1'b0;
      gap_left = 0;
    end else begin
      drv_valid = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        expected_points.insert(expected_points.size(), eval_curve_point(cur_item));
        n_sent++;
        if (cur_item.k > STEPS) n_clamped++;
        drv_valid = 1'b0;
      end
      if (!drv_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(0, 5);
        end else if (pending_ctrl.size() > 0) begin
          cur_item = pending_ctrl.pop_front();
          in_ch.p1_x         <= cur_item.p1_x;
          in_ch.p1_y         <= cur_item.p1_y;
          in_ch.p2_x         <= cur_item.p2_x;
          in_ch.p2_y         <= cur_item.p2_y;
          in_ch.p3_x         <= cur_item.p3_x;
          in_ch.p3_y         <= cur_item.p3_y;
          in_ch.p4_x         <= cur_item.p4_x;
          in_ch.p4_y         <= cur_item.p4_y;
          in_ch.sample_index <= cur_item.k;
          drv_valid = 1'b1;
        end
      end
      in_ch.valid <= drv_valid;
      quiet       <= (pending_ctrl.size() < QUIET_TAIL);
    end
  end

  // Monitor
  always @(posedge clk) begin : monitor
    curve_pt_t want;
    logic      nxt_ready;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_recv++;
        if (expected_points.size() == 0) begin
          note_error($sformatf("unexpected point x=%0d y=%0d",
                               out_ch.point_x, out_ch.point_y));
        end else begin
          want = expected_points.pop_front();
          if (out_ch.point_x !== want.x || out_ch.point_y !== want.y)
            note_error($sformatf("point mismatch: exp x=%0d y=%0d, got x=%0d y=%0d",
                                 want.x, want.y, out_ch.point_x, out_ch.point_y));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      out_ch.ready <= nxt_ready;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.p1_x         = '0;
    in_ch.p1_y         = '0;
    in_ch.p2_x         = '0;
    in_ch.p2_y         = '0;
    in_ch.p3_x         = '0;
    in_ch.p3_y         = '0;
    in_ch.p4_x         = '0;
    in_ch.p4_y         = '0;
    in_ch.sample_index = '0;
    out_ch.ready       = 1'b0;
    n_sent      = 0;
    n_recv      = 0;
    n_clamped   = 0;
    n_errors    = 0;
    idle_cycles = 0;

    // directed: field extremes, endpoints, clamped indexes
    queue_item(make_ctrl(-32768, -32768, -32768, -32768,
                         -32768, -32768, -32768, -32768, 0));
    queue_item(make_ctrl(-32768, -32768, -32768, -32768,
                         -32768, -32768, -32768, -32768, 50));
    queue_item(make_ctrl(-32768, -32768, -32768, -32768,
                         -32768, -32768, -32768, -32768, 100));
    queue_item(make_ctrl(32767, 32767, 32767, 32767,
                         32767, 32767, 32767, 32767, 0));
    queue_item(make_ctrl(32767, 32767, 32767, 32767,
                         32767, 32767, 32767, 32767, 37));
    queue_item(make_ctrl(32767, 32767, 32767, 32767,
                         32767, 32767, 32767, 32767, 100));
    queue_item(make_ctrl(32767, -32768, -32768, 32767,
                         -32768, 32767, -32768, 32767, 100));
    queue_item(make_ctrl(32767, -32768, -32768, 32767,
                         -32768, 32767, -32768, 32767, 99));
    queue_item(make_ctrl(-32768, 32767, -32768, 32767,
                         -32768, 32767, 32767, -32768, 0));
    queue_item(make_ctrl(-32768, 32767, -32768, 32767,
                         -32768, 32767, 32767, -32768, 1));
    queue_item(make_ctrl(0, 0, 32767, 32767, -32768, -32768, 0, 0, 50));
    queue_item(make_ctrl(0, 0, -32768, -32768, 32767, 32767, 0, 0, 33));
    queue_item(make_ctrl(-1, -1, -1, -1, -1, -1, -1, -1, 67));
    queue_item(make_ctrl(1, -1, 0, 0, 0, 0, 0, 0, 1));
    queue_item(make_ctrl(1234, -4321, 200, -300, 17, 99, -555, 666, 101));
    queue_item(make_ctrl(1234, -4321, 200, -300, 17, 99, -555, 666, 127));
    queue_item(make_ctrl(-7, 8, 32767, -32768, 32767, -32768, 5, -6, 64));
    queue_item(make_ctrl(-32768, -32768, 32767, 32767,
                         32767, 32767, -32768, -32768, 50));
    queue_item(make_ctrl(32767, 32767, -32768, -32768,
                         -32768, -32768, 32767, 32767, 50));
    queue_item(make_ctrl(100, 200, 300, 400, 500, 600, 700, 800, 99));

    for (int i = 0; i < RANDOM_ITEMS; i++)
      queue_item(rand_ctrl());

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_ctrl.size() != 0 || in_ch.valid || expected_points.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d control-point transactions (%0d with index above STEPS),",
             n_sent, n_clamped);
    $display("checked %0d curve points under random gaps and stalls; %0d mismatches.",
             n_recv, n_errors);
    if (n_errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
